// ===== rtl/bvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_pkg: shared types and constants for the boundary vertex variant dedup
// Transaction payloads, variant row layout, controller commands and codes.
// ----------------------------------------------------------------------------
package bvd_pkg;

	localparam int POINTS   = 1024;
	localparam int VARIANTS = 6;
	localparam int STREAMS  = 4;

	localparam int PT_W     = 10;
	localparam int REGION_W = 16;
	localparam int SIG_W    = STREAMS * REGION_W;
	localparam int VTX_W    = 24;
	localparam int CNT_W    = 3;
	localparam int CFG_W    = 3;
	localparam int RSV_W    = 16;

	localparam logic OP_MAP     = 1'b0;
	localparam logic OP_RESERVE = 1'b1;

	localparam logic [1:0] ACT_EVAL = 2'd0;
	localparam logic [1:0] ACT_SKIP = 2'd1;
	localparam logic [1:0] ACT_COPY = 2'd2;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(STREAMS);

	typedef struct packed {
		logic                op;
		logic [PT_W-1:0]     point_index;
		logic [REGION_W-1:0] region_0;
		logic [REGION_W-1:0] region_1;
		logic [REGION_W-1:0] region_2;
		logic [REGION_W-1:0] region_3;
		logic [RSV_W-1:0]    reserve_count;
	} req_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex_id;
		logic             is_new;
		logic             overflow;
		logic [1:0]       action_0;
		logic [1:0]       action_1;
		logic [1:0]       action_2;
		logic [1:0]       action_3;
		logic [VTX_W-1:0] copy_source_0;
		logic [VTX_W-1:0] copy_source_1;
		logic [VTX_W-1:0] copy_source_2;
		logic [VTX_W-1:0] copy_source_3;
	} result_t;

	typedef struct packed {
		logic [SIG_W-1:0] sig;
		logic [VTX_W-1:0] vtx;
	} variant_t;

	typedef variant_t [VARIANTS-1:0] row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic clear;
		logic lookup;
		logic resolve;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} status_t;

endpackage

// ===== rtl/boundary_vertex_variant_dedup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_vertex_variant_dedup: per-point vertex variant deduplication
// Maps a boundary point and its region signature to a vertex index and
// reports per-stream skip, copy or evaluate actions; reserves interior blocks.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge where start is high and busy is low.
// Each transaction runs a lookup and then a resolve: the lookup reads the point's variant row
// and count from the row memory (registered read), the resolve does the
// match and copy search and writes the row back when a new variant is recorded;
// busy drops again in the cycle the result appears, so no new transaction is
// taken until the result appears. The result is driven for exactly one cycle
// with done high, once the row read and the resolve result are registered;
// the receiver cannot hold it off and must take it. After reset, busy stays
// high while the per-point variant counts are cleared one point per cycle.
// Write active_streams only while the block is idle.
// ----------------------------------------------------------------------------
module boundary_vertex_variant_dedup
	import bvd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	// sequence clearing, accept and resolve
	bvd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the variant store, counter and output register
	bvd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	// an accepted transaction produces its result once the row read and the resolve are registered
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after acceptance");

	// results never come in consecutive cycles
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// no acceptance while a transaction is being resolved
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low during resolve");

	// overflow only comes with a newly allocated vertex
	a_overflow_new: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |-> result.is_new)
		else $error("overflow without allocation");

	// reserve and exact match report skip on every stream
	a_skip_all: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_new) |->
		(result.action_0 == ACT_SKIP && result.action_1 == ACT_SKIP &&
		 result.action_2 == ACT_SKIP && result.action_3 == ACT_SKIP))
		else $error("non-skip action without allocation");

endmodule

// ===== rtl/bvd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_ctrl: sequencing state machine
// Runs the count clearing pass, accepts a transaction, then resolves it.
// ----------------------------------------------------------------------------
module bvd_ctrl
	import bvd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		busy        = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.lookup = 1'b1;
					state_d    = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/bvd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_dp: variant store, vertex counter and resolve logic
// Registered row read on lookup, match and copy search plus write-back on
// resolve, one-cycle result strobe.
// ----------------------------------------------------------------------------
module bvd_dp
	import bvd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             done,
	output result_t          result
);

	// storage
	row_t             row_mem [POINTS];
	logic [CNT_W-1:0] cnt_mem [POINTS];

	logic [CFG_W-1:0]   active_q;
	logic [VTX_W-1:0]   next_q;
	logic [PT_W-1:0]    clr_addr_q;
	req_t               req_q;
	logic [SIG_W-1:0]   sig_q;
	logic [STREAMS-1:0] mask_q;
	row_t               row_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic               done_q;
	result_t            result_q;

	// lookup side
	logic [CFG_W-1:0]    n_streams;
	logic [STREAMS-1:0]  mask_d;
	logic [REGION_W-1:0] regions [STREAMS];
	logic [SIG_W-1:0]    sig_d;

	// resolve side
	logic [CNT_W-1:0]   cnt;
	logic               hit;
	logic [VTX_W-1:0]   hit_vtx;
	logic [1:0]         act [STREAMS];
	logic [VTX_W-1:0]   src [STREAMS];
	logic               record;
	row_t               row_wr;
	result_t            result_d;
	logic [VTX_W-1:0]   next_d;

	assign status.clear_last = (clr_addr_q == PT_W'(POINTS - 1));

	always_comb begin
		regions[0] = req.region_0;
		regions[1] = req.region_1;
		regions[2] = req.region_2;
		regions[3] = req.region_3;
		if (active_q == '0) begin
			n_streams = CFG_W'(1);
		end else if (active_q > CFG_W'(STREAMS)) begin
			n_streams = CFG_W'(STREAMS);
		end else begin
			n_streams = active_q;
		end
		for (int s = 0; s < STREAMS; s++) begin
			mask_d[s] = (CFG_W'(s) < n_streams);
			sig_d[s*REGION_W +: REGION_W] = regions[s] & {REGION_W{mask_d[s]}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RESET;
			next_q     <= '0;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + PT_W'(1);
			end
			if (cmd.resolve) begin
				next_q <= next_d;
			end
			done_q <= cmd.resolve;
		end
	end

	// capture the request and fetch the point's row and count; register the result on resolve
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			req_q    <= req;
			sig_q    <= sig_d;
			mask_q   <= mask_d;
			row_rd_q <= row_mem[req.point_index];
			cnt_rd_q <= cnt_mem[req.point_index];
		end
		if (cmd.resolve) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve && record) begin
			row_mem[req_q.point_index] <= row_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			cnt_mem[clr_addr_q] <= '0;
		end else if (cmd.resolve && record) begin
			cnt_mem[req_q.point_index] <= cnt + CNT_W'(1);
		end
	end

	always_comb begin
		cnt = (cnt_rd_q > CNT_W'(VARIANTS)) ? CNT_W'(VARIANTS) : cnt_rd_q;

		// downward scan leaves the oldest matching variant selected
		hit     = 1'b0;
		hit_vtx = '0;
		for (int v = VARIANTS - 1; v >= 0; v--) begin
			if ((CNT_W'(v) < cnt) && (row_rd_q[v].sig == sig_q)) begin
				hit     = 1'b1;
				hit_vtx = row_rd_q[v].vtx;
			end
		end

		for (int s = 0; s < STREAMS; s++) begin
			act[s] = mask_q[s] ? ACT_EVAL : ACT_SKIP;
			src[s] = '0;
			for (int v = VARIANTS - 1; v >= 0; v--) begin
				if (mask_q[s] && (CNT_W'(v) < cnt) &&
				    (row_rd_q[v].sig[s*REGION_W +: REGION_W] ==
				     sig_q[s*REGION_W +: REGION_W])) begin
					act[s] = ACT_COPY;
					src[s] = row_rd_q[v].vtx;
				end
			end
		end

		record = (req_q.op == OP_MAP) && !hit && (cnt < CNT_W'(VARIANTS));

		for (int v = 0; v < VARIANTS; v++) begin
			if (CNT_W'(v) == cnt) begin
				row_wr[v].sig = sig_q;
				row_wr[v].vtx = next_q;
			end else begin
				row_wr[v] = row_rd_q[v];
			end
		end

		result_d.vertex_id     = next_q;
		result_d.is_new        = 1'b0;
		result_d.overflow      = 1'b0;
		result_d.action_0      = ACT_SKIP;
		result_d.action_1      = ACT_SKIP;
		result_d.action_2      = ACT_SKIP;
		result_d.action_3      = ACT_SKIP;
		result_d.copy_source_0 = '0;
		result_d.copy_source_1 = '0;
		result_d.copy_source_2 = '0;
		result_d.copy_source_3 = '0;
		next_d                 = next_q;

		if (req_q.op == OP_RESERVE) begin
			next_d = next_q + VTX_W'(req_q.reserve_count);
		end else if (hit) begin
			result_d.vertex_id = hit_vtx;
		end else begin
			next_d                 = next_q + VTX_W'(1);
			result_d.is_new        = 1'b1;
			result_d.overflow      = (cnt == CNT_W'(VARIANTS));
			result_d.action_0      = act[0];
			result_d.action_1      = act[1];
			result_d.action_2      = act[2];
			result_d.action_3      = act[3];
			result_d.copy_source_0 = src[0];
			result_d.copy_source_1 = src[1];
			result_d.copy_source_2 = src[2];
			result_d.copy_source_3 = src[3];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
